// ----- design/qev_pkg.sv -----
// Shared types and constants for the four-channel encoder velocity PI block.
// Used by qev_ctrl, qev_datapath and quad_encoder_velocity_pi.
package qev_pkg;

    // Encoder count width; only the low CNT_W bits of each count are used
    localparam int CNT_W   = 32;
    localparam int CH_N    = 4;
    localparam int CH_W    = $clog2(CH_N);
    // Microseconds per second: the velocity scale factor
    localparam int MEGA_W  = 20;
    localparam logic [MEGA_W-1:0] MEGA = MEGA_W'(1000000);
    // |delta| * dist_per_count
    localparam int NUM_W   = CNT_W + 32;
    // (num * 10^6) >> 16, the dividend of the per-tick division
    localparam int DIVD_W  = NUM_W + MEGA_W - 16;
    localparam int DCNT_W  = $clog2(DIVD_W);
    localparam int TICK_W  = 20;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_DIST  = 2'd0;
    localparam logic [1:0] REG_GAINP = 2'd1;
    localparam logic [1:0] REG_GAINI = 2'd2;
    localparam logic [1:0] REG_LIMIT = 2'd3;

    // Datapath operations, one per controller step
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DELTA,
        OP_MLO,
        OP_MHI,
        OP_DIV,
        OP_PI,
        OP_GAIN,
        OP_STORE
    } op_t;

    typedef struct packed {
        logic             load;
        logic             clear;
        logic             publish;
        op_t              op;
        logic [CH_W-1:0]  ch;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } status_t;

endpackage

// ----- design/qev_ctrl.sv -----
// Sequencer for the encoder velocity PI block: steps each channel through
// delta, scaling, serial division and PI update. Depends on qev_pkg.
module qev_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_command,
    output logic            s_ready,
    output qev_pkg::cmd_t   cmd,
    input  qev_pkg::status_t status
);
    import qev_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DELTA, S_MLO, S_MHI, S_DIV, S_PI, S_GAIN, S_STORE, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;

    // Next state and step counters
    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        dcnt_next  = dcnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && !s_command) begin
                    state_next = S_DELTA;
                    ch_next    = '0;
                end
            end
            S_DELTA: state_next = S_MLO;
            S_MLO:   state_next = S_MHI;
            S_MHI: begin
                state_next = S_DIV;
                dcnt_next  = '0;
            end
            S_DIV: begin
                if (dcnt_reg == DCNT_W'(DIVD_W - 1)) begin
                    state_next = S_PI;
                end else begin
                    dcnt_next = dcnt_reg + 1'b1;
                end
            end
            S_PI:   state_next = S_GAIN;
            S_GAIN: state_next = S_STORE;
            S_STORE: begin
                if (ch_reg == CH_W'(CH_N - 1)) begin
                    state_next = S_DONE;
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_DELTA;
                end
            end
            S_DONE: begin
                if (!status.out_full) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
            dcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // Decode commands to the datapath
    always_comb begin
        cmd         = '0;
        cmd.ch      = ch_reg;
        cmd.load    = (state_reg == S_IDLE) && s_valid && !s_command;
        cmd.clear   = (state_reg == S_IDLE) && s_valid && s_command;
        cmd.publish = (state_reg == S_DONE) && !status.out_full;
        case (state_reg)
            S_DELTA: cmd.op = OP_DELTA;
            S_MLO:   cmd.op = OP_MLO;
            S_MHI:   cmd.op = OP_MHI;
            S_DIV:   cmd.op = OP_DIV;
            S_PI:    cmd.op = OP_PI;
            S_GAIN:  cmd.op = OP_GAIN;
            S_STORE: cmd.op = OP_STORE;
            default: cmd.op = OP_NONE;
        endcase
    end

    // A clear beat starts no channel work
    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command |=> state_reg == S_IDLE)
        else $error("clear beat left idle");

    // The division runs exactly DIVD_W steps
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> dcnt_reg < DCNT_W'(DIVD_W))
        else $error("division step count overrun");

    // A result is never published over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> !status.out_full)
        else $error("result overwritten");

endmodule

// ----- design/qev_datapath.sv -----
// Arithmetic for the encoder velocity PI block: per-channel state, scaling
// multipliers, restoring divider, PI update and output register. Uses qev_pkg.
module qev_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  qev_pkg::cmd_t                cmd,
    output qev_pkg::status_t             status,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic signed [31:0]           s_setpoint,
    input  logic [qev_pkg::TICK_W-1:0]   s_tick_us,
    input  logic signed [31:0]           s_count_a,
    input  logic signed [31:0]           s_count_b,
    input  logic signed [31:0]           s_count_c,
    input  logic signed [31:0]           s_count_d,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [31:0]           m_drive_a,
    output logic signed [31:0]           m_drive_b,
    output logic signed [31:0]           m_drive_c,
    output logic signed [31:0]           m_drive_d
);
    import qev_pkg::*;

    logic [31:0]              dist_reg;
    logic [23:0]              gainp_reg, gaini_reg;
    logic [30:0]              limit_reg;

    logic signed [31:0]       sp_reg;
    logic [TICK_W-1:0]        tick_reg;
    logic [CNT_W-1:0]         cnt_reg  [CH_N];
    logic [CNT_W-1:0]         last_reg [CH_N];
    logic signed [31:0]       acc_reg  [CH_N];
    logic signed [31:0]       drv_reg  [CH_N];

    logic                     neg_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [31+MEGA_W:0]       plo_reg;
    logic [DIVD_W-1:0]        divd_reg;
    logic [TICK_W-1:0]        rem_reg;
    logic [31:0]              quot_reg;
    logic                     sat_reg;
    logic signed [33:0]       err_reg;
    logic signed [31:0]       accn_reg;
    logic signed [58:0]       pp_reg;
    logic signed [56:0]       ip_reg;

    logic                     m_valid_reg;
    logic signed [31:0]       out_reg [CH_N];

    // Delta and magnitude
    logic [CNT_W-1:0]         delta;
    logic [CNT_W-1:0]         dmag;
    always_comb begin
        delta = cnt_reg[cmd.ch] - last_reg[cmd.ch];
        dmag  = delta[CNT_W-1] ? (~delta + 1'b1) : delta;
    end

    // Dividend: (hi * 10^6) << 32 plus the low partial product, then >> 16
    logic [CNT_W+MEGA_W-1:0]  phi_prod;
    logic [CNT_W+MEGA_W+31:0] full_prod;
    always_comb begin
        phi_prod  = (CNT_W+MEGA_W)'(num_reg[NUM_W-1:32]) * (CNT_W+MEGA_W)'(MEGA);
        full_prod = {phi_prod, 32'b0}
                  + (CNT_W+MEGA_W+32)'(plo_reg);
    end

    // One restoring division step
    logic [TICK_W:0]          trial;
    logic                     ge;
    logic [TICK_W:0]          trial_sub;
    always_comb begin
        trial     = {rem_reg, divd_reg[DIVD_W-1]};
        ge        = trial >= {1'b0, tick_reg};
        trial_sub = trial - {1'b0, tick_reg};
    end

    // Velocity from the quotient, saturated to the signed 32-bit range
    logic [31:0]              vmag;
    logic signed [31:0]       vel;
    always_comb begin
        vmag = (sat_reg || quot_reg > 32'h8000_0000) ? 32'h8000_0000 : quot_reg;
        if (neg_reg) begin
            vel = -$signed(vmag);
        end else begin
            vel = vmag[31] ? 32'sh7FFF_FFFF : $signed(vmag);
        end
    end

    // Error and clamped integral
    logic signed [33:0]       err;
    logic signed [33:0]       accsum;
    logic signed [33:0]       lim;
    logic signed [31:0]       accn;
    always_comb begin
        err    = 34'(sp_reg) - 34'(vel);
        accsum = 34'(acc_reg[cmd.ch]) + err;
        lim    = $signed({3'b0, limit_reg});
        if (accsum > lim) begin
            accn = 32'(lim);
        end else if (accsum < -lim) begin
            accn = 32'(-lim);
        end else begin
            accn = 32'(accsum);
        end
    end

    // Drive sum and saturation
    logic signed [43:0]       dsum;
    logic signed [31:0]       drive;
    always_comb begin
        dsum = 44'(pp_reg >>> 16) + 44'(ip_reg >>> 16);
        if (dsum > 44'sh0_7FFF_FFFF) begin
            drive = 32'sh7FFF_FFFF;
        end else if (dsum < -44'sh0_8000_0000) begin
            drive = -32'sh8000_0000;
        end else begin
            drive = 32'(dsum);
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg  <= '0;
            gainp_reg <= '0;
            gaini_reg <= '0;
            limit_reg <= '1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DIST:  dist_reg  <= cfg_data;
                REG_GAINP: gainp_reg <= cfg_data[23:0];
                REG_GAINI: gaini_reg <= cfg_data[23:0];
                REG_LIMIT: limit_reg <= cfg_data[30:0];
                default:   dist_reg  <= dist_reg;
            endcase
        end
    end

    // Channel state: previous counts and integrals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CH_N; k++) begin
                last_reg[k] <= '0;
                acc_reg[k]  <= '0;
            end
        end else if (cmd.clear) begin
            for (int k = 0; k < CH_N; k++) begin
                acc_reg[k] <= '0;
            end
        end else if (cmd.op == OP_STORE) begin
            acc_reg[cmd.ch]  <= accn_reg;
            last_reg[cmd.ch] <= cnt_reg[cmd.ch];
        end
    end

    // Capture the beat and run the arithmetic steps
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sp_reg     <= s_setpoint;
            tick_reg   <= (s_tick_us == '0) ? TICK_W'(1) : s_tick_us;
            cnt_reg[0] <= s_count_a[CNT_W-1:0];
            cnt_reg[1] <= s_count_b[CNT_W-1:0];
            cnt_reg[2] <= s_count_c[CNT_W-1:0];
            cnt_reg[3] <= s_count_d[CNT_W-1:0];
        end
        case (cmd.op)
            OP_DELTA: begin
                neg_reg <= delta[CNT_W-1];
                num_reg <= dmag * dist_reg;
            end
            OP_MLO: plo_reg <= num_reg[31:0] * MEGA;
            OP_MHI: begin
                divd_reg <= full_prod[CNT_W+MEGA_W+31:16];
                rem_reg  <= '0;
                quot_reg <= '0;
                sat_reg  <= 1'b0;
            end
            OP_DIV: begin
                divd_reg <= {divd_reg[DIVD_W-2:0], 1'b0};
                rem_reg  <= ge ? trial_sub[TICK_W-1:0] : trial[TICK_W-1:0];
                quot_reg <= {quot_reg[30:0], ge};
                sat_reg  <= sat_reg | quot_reg[31];
            end
            OP_PI: begin
                err_reg  <= err;
                accn_reg <= accn;
            end
            OP_GAIN: begin
                pp_reg <= err_reg * $signed({1'b0, gainp_reg});
                ip_reg <= accn_reg * $signed({1'b0, gaini_reg});
            end
            OP_STORE: drv_reg[cmd.ch] <= drive;
            default:  neg_reg <= neg_reg;
        endcase
    end

    // Output register: hold the result until the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            for (int k = 0; k < CH_N; k++) begin
                out_reg[k] <= drv_reg[k];
            end
        end
    end

    assign status.out_full = m_valid_reg && !m_ready;
    assign m_valid   = m_valid_reg;
    assign m_drive_a = out_reg[0];
    assign m_drive_b = out_reg[1];
    assign m_drive_c = out_reg[2];
    assign m_drive_d = out_reg[3];

endmodule

// ----- design/quad_encoder_velocity_pi.sv -----
// Top level of the four-channel encoder velocity PI controller.
// Instantiates qev_ctrl and qev_datapath; types from qev_pkg.

// Each update beat carries four encoder counts, a shared Q16.16 velocity
// setpoint and the tick length in microseconds; one beat of four saturated
// Q16.16 drive values follows. The channels share one datapath and are done
// in turn, each through scaling (delta, low and high product), bit-serial
// division by the tick length and the PI update (error, gains, store); the
// next beat is accepted once the result sits in the output register. A clear
// beat (command high) zeroes the integrals and gives no result. Configuration
// writes take effect at once and must be made while the block is idle.
module quad_encoder_velocity_pi (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic signed [31:0]           s_setpoint,
    input  logic [qev_pkg::TICK_W-1:0]   s_tick_us,
    input  logic signed [31:0]           s_count_a,
    input  logic signed [31:0]           s_count_b,
    input  logic signed [31:0]           s_count_c,
    input  logic signed [31:0]           s_count_d,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [31:0]           m_drive_a,
    output logic signed [31:0]           m_drive_b,
    output logic signed [31:0]           m_drive_c,
    output logic signed [31:0]           m_drive_d
);
    import qev_pkg::*;

    cmd_t    cmd;
    status_t status;

    qev_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .cmd       (cmd),
        .status    (status)
    );

    qev_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_setpoint (s_setpoint),
        .s_tick_us  (s_tick_us),
        .s_count_a  (s_count_a),
        .s_count_b  (s_count_b),
        .s_count_c  (s_count_c),
        .s_count_d  (s_count_d),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive_a  (m_drive_a),
        .m_drive_b  (m_drive_b),
        .m_drive_c  (m_drive_c),
        .m_drive_d  (m_drive_d)
    );

endmodule
